// File: sv/pcs_pkg.sv
// Shared types, constants and helpers of the configuration space scan engine.
package pcs_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned BAR_COUNT_DEF     = 6;
  localparam int unsigned SLOTS_PER_BUS_DEF = 32;

  // Result queue depth; an item yields at most two result beats
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // Register map
  localparam int unsigned APB_AW   = 3;
  localparam int unsigned BUS_LIM_W = 9;
  localparam logic [BUS_LIM_W-1:0] BUS_LIMIT_RST = 9'd8;
  localparam logic REG_BUS_LIMIT = 1'b0;

  // Configuration dword offsets
  localparam logic [7:0] OFF_ID   = 8'h00;
  localparam logic [7:0] OFF_HDR  = 8'h0C;
  localparam logic [7:0] OFF_BAR0 = 8'h10;
  localparam logic [7:0] OFF_IRQ  = 8'h3C;
  localparam logic [15:0] VENDOR_NONE = 16'hFFFF;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_DATA  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_REQ  = 2'd0,
    KIND_BAR  = 2'd1,
    KIND_IRQ  = 2'd2,
    KIND_DONE = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_ID0  = 3'd1,
    PH_HDR  = 3'd2,
    PH_IDF  = 3'd3,
    PH_BAR  = 3'd4,
    PH_IRQ  = 3'd5
  } phase_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [15:0] target_vendor;
    logic [15:0] target_device;
    logic [31:0] read_data;
  } in_t;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] config_address;
    logic [7:0]  bus_number;
    logic [4:0]  slot_number;
    logic [2:0]  function_number;
    logic [2:0]  bar_index;
    logic [31:0] report_value;
    logic        found;
    logic        last;
  } res_t;

  // Build a read request beat carrying its CONFIG_ADDRESS style address (enable, bus, slot, function, dword offset)
  function automatic res_t mk_req(logic [7:0] bus, logic [4:0] slot, logic [2:0] fn,
                                  logic [7:0] off);
    res_t r;
    r = '0;
    r.kind            = KIND_REQ;
    r.config_address  = {1'b1, 7'd0, bus, slot, fn, off[7:2], 2'b00};
    r.bus_number      = bus;
    r.slot_number     = slot;
    r.function_number = fn;
    return r;
  endfunction

  // Build a report or finish beat
  function automatic res_t mk_rep(kind_e kind, logic [7:0] bus, logic [4:0] slot,
                                  logic [2:0] fn, logic [2:0] bidx, logic [31:0] val,
                                  logic fnd, logic lst);
    res_t r;
    r = '0;
    r.kind            = kind;
    r.bus_number      = bus;
    r.slot_number     = slot;
    r.function_number = fn;
    r.bar_index       = bidx;
    r.report_value    = val;
    r.found           = fnd;
    r.last            = lst;
    return r;
  endfunction

endpackage

// File: sv/pcs_in_if.sv
// Input channel: command and read data beats.
interface pcs_in_if import pcs_pkg::*; ();
  logic valid;
  logic ready;
  in_t  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: sv/pcs_out_if.sv
// Output channel: read requests, reports and finish beats.
interface pcs_out_if import pcs_pkg::*; ();
  logic valid;
  logic ready;
  res_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: sv/pci_config_scan_engine.sv
// Top level of the configuration space scan engine.
// Usage:
//   in_ch carries beats of two kinds. A start beat latches the vendor and
//   device IDs and yields the first read request. A data beat delivers the
//   word of the last requested configuration read and advances the scan.
//   out_ch carries read requests, BAR reports, the IRQ line report and the
//   finish beat (last set, found tells whether a function matched).
//   The APB port holds bus_limit at address 0 (reset 8).
// Timing:
//   A beat's results are written into the registered output queue when it
//   is accepted. One input beat is taken every cycle while the four-entry
//   output queue has room for two results; a BAR or IRQ beat yields two
//   results, so the sustained rate is set by how fast out_ch drains.
// Reset clears the scan state and the queue and returns bus_limit to 8.
// When out_ch stalls, results wait in the queue and in_ch drops ready
// once fewer than two entries are free.
module pci_config_scan_engine import pcs_pkg::*; #(
  parameter int unsigned BAR_COUNT     = BAR_COUNT_DEF,
  parameter int unsigned SLOTS_PER_BUS = SLOTS_PER_BUS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  pcs_in_if.sink            in_ch,
  pcs_out_if.source         out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam logic [2:0] BAR_LIM  = 3'(BAR_COUNT);
  localparam logic [5:0] SLOT_LIM = 6'(SLOTS_PER_BUS);

  logic [BUS_LIM_W-1:0] bus_limit_q;

  phase_e      phase_q, phase_d;
  logic [7:0]  bus_q, bus_d;
  logic [4:0]  slot_q, slot_d;
  logic [2:0]  fn_q, fn_d;
  logic [2:0]  bar_q, bar_d;
  logic [15:0] vend_q, vend_d;
  logic [15:0] dev_q, dev_d;

  res_t              q_q [QDEPTH];
  res_t              q_d [QDEPTH];
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  logic        in_acc, pop;
  logic [1:0]  nres;
  res_t        r0, r1;
  logic        go_next, go_bar, is_match;
  logic [8:0]  nb;
  logic [4:0]  slot_inc;
  logic [2:0]  bar_nx;
  logic [31:0] data;
  logic [QCNT_W-1:0] base;

  // APB register port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_BUS_LIMIT) ? {{(32-BUS_LIM_W){1'b0}}, bus_limit_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bus_limit_q <= BUS_LIMIT_RST;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_BUS_LIMIT)) begin
      bus_limit_q <= pwdata[BUS_LIM_W-1:0];
    end
  end

  // Handshakes
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign pop          = out_ch.valid && out_ch.ready;
  assign in_ch.ready  = (cnt_q <= QCNT_W'(QDEPTH - 2));
  assign out_ch.valid = (cnt_q != '0);
  assign out_ch.data  = q_q[0];

  assign data     = in_ch.data.read_data;
  assign is_match = (data[15:0] == vend_q) && (data[31:16] == dev_q);
  assign nb       = {1'b0, bus_q} + 9'd1;
  assign slot_inc = slot_q + 5'd1;
  assign bar_nx   = bar_q + 3'd1;

  // Scan state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      bus_q   <= '0;
      slot_q  <= '0;
      fn_q    <= '0;
      bar_q   <= '0;
      vend_q  <= '0;
      dev_q   <= '0;
    end else begin
      phase_q <= phase_d;
      bus_q   <= bus_d;
      slot_q  <= slot_d;
      fn_q    <= fn_d;
      bar_q   <= bar_d;
      vend_q  <= vend_d;
      dev_q   <= dev_d;
    end
  end

  // Advance the scan by one beat and form its result beats
  always_comb begin
    phase_d = phase_q;
    bus_d   = bus_q;
    slot_d  = slot_q;
    fn_d    = fn_q;
    bar_d   = bar_q;
    vend_d  = vend_q;
    dev_d   = dev_q;
    nres    = 2'd0;
    r0      = '0;
    r1      = '0;
    go_next = 1'b0;
    go_bar  = 1'b0;
    if (in_acc) begin
      if (in_ch.data.cmd == CMD_START) begin
        vend_d  = in_ch.data.target_vendor;
        dev_d   = in_ch.data.target_device;
        bus_d   = '0;
        slot_d  = '0;
        fn_d    = '0;
        bar_d   = '0;
        phase_d = PH_ID0;
        r0      = mk_req(8'd0, 5'd0, 3'd0, OFF_ID);
        nres    = 2'd1;
      end else begin
        unique case (phase_q)
          PH_ID0: begin
            if (data[15:0] == VENDOR_NONE) begin
              go_next = 1'b1;
            end else if (is_match) begin
              go_bar = 1'b1;
            end else begin
              phase_d = PH_HDR;
              r0      = mk_req(bus_q, slot_q, fn_q, OFF_HDR);
              nres    = 2'd1;
            end
          end
          PH_HDR: begin
            // header type bit 7 marks a multi-function device
            if (data[23]) begin
              fn_d    = 3'd1;
              phase_d = PH_IDF;
              r0      = mk_req(bus_q, slot_q, 3'd1, OFF_ID);
              nres    = 2'd1;
            end else begin
              go_next = 1'b1;
            end
          end
          PH_IDF: begin
            if ((data[15:0] != VENDOR_NONE) && is_match) begin
              go_bar = 1'b1;
            end else if (fn_q == 3'd7) begin
              go_next = 1'b1;
            end else begin
              fn_d = fn_q + 3'd1;
              r0   = mk_req(bus_q, slot_q, fn_q + 3'd1, OFF_ID);
              nres = 2'd1;
            end
          end
          PH_BAR: begin
            r0    = mk_rep(KIND_BAR, bus_q, slot_q, fn_q, bar_q, data, 1'b0, 1'b0);
            bar_d = bar_nx;
            if (bar_nx < BAR_LIM) begin
              r1 = mk_req(bus_q, slot_q, fn_q, OFF_BAR0 + {3'd0, bar_nx, 2'b00});
            end else begin
              phase_d = PH_IRQ;
              r1      = mk_req(bus_q, slot_q, fn_q, OFF_IRQ);
            end
            nres = 2'd2;
          end
          PH_IRQ: begin
            r0      = mk_rep(KIND_IRQ, bus_q, slot_q, fn_q, 3'd0, {24'd0, data[7:0]},
                             1'b0, 1'b0);
            r1      = mk_rep(KIND_DONE, bus_q, slot_q, fn_q, 3'd0, 32'd0, 1'b1, 1'b1);
            phase_d = PH_IDLE;
            nres    = 2'd2;
          end
          default: begin
            // data while idle is dropped
          end
        endcase
      end
    end

    // Matching function: start the BAR reads
    if (go_bar) begin
      phase_d = PH_BAR;
      bar_d   = '0;
      r0      = mk_req(bus_q, slot_q, fn_q, OFF_BAR0);
      nres    = 2'd1;
    end

    // Move on to the next slot, the next bus or finish
    if (go_next) begin
      fn_d = '0;
      nres = 2'd1;
      if ((slot_inc == 5'd0) || ({1'b0, slot_inc} >= SLOT_LIM)) begin
        slot_d = '0;
        if ((nb >= bus_limit_q) || nb[8]) begin
          phase_d = PH_IDLE;
          r0      = mk_rep(KIND_DONE, bus_q, 5'd0, 3'd0, 3'd0, 32'd0, 1'b0, 1'b1);
        end else begin
          bus_d   = nb[7:0];
          phase_d = PH_ID0;
          r0      = mk_req(nb[7:0], 5'd0, 3'd0, OFF_ID);
        end
      end else begin
        slot_d  = slot_inc;
        phase_d = PH_ID0;
        r0      = mk_req(bus_q, slot_inc, 3'd0, OFF_ID);
      end
    end
  end

  // Output queue: shift on pop, append new beats behind the survivors
  always_comb begin
    base = cnt_q - QCNT_W'(pop);
    for (int i = 0; i < QDEPTH; i++) begin
      if (pop && (i < QDEPTH - 1)) begin
        q_d[i] = q_q[(i + 1) % QDEPTH];
      end else begin
        q_d[i] = q_q[i];
      end
      if ((nres != 2'd0) && (QCNT_W'(i) == base)) begin
        q_d[i] = r0;
      end
      if ((nres == 2'd2) && (QCNT_W'(i) == base + QCNT_W'(1))) begin
        q_d[i] = r1;
      end
    end
    cnt_d = base + QCNT_W'(nres);
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < QDEPTH; i++) begin
      q_q[i] <= q_d[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCNT_W'(QDEPTH))
    else $error("result queue overfilled");

  a_start_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_ch.data.cmd == CMD_START) |=> (phase_q == PH_ID0) && (bus_q == 8'd0)
      && (slot_q == 5'd0))
    else $error("start beat did not restart the scan");

  a_idle_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_ch.data.cmd == CMD_DATA) && (phase_q == PH_IDLE)
      |=> cnt_q == $past(cnt_q - QCNT_W'(pop)))
    else $error("data beat while idle produced a result");

  a_bar_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_BAR) |-> (bar_q < BAR_LIM))
    else $error("BAR counter out of range");

  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, slot_q} < SLOT_LIM)
    else $error("slot beyond slots per bus");
`endif

endmodule

// File: verif/testbench.sv
// Self-checking bench for the configuration space scan engine: directed table, then random scans.
module testbench;
  import pcs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int PREDICTED   = -1;       // row checked against the predictor
  localparam int PER_SETTING = 218;      // counted beats per bus_limit setting
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_LIMIT = 5000;
  localparam int SETTLE      = 8;        // cycles after the last result before a register write

  logic clk_i = 1'b0;
  logic rst_ni;

  pcs_in_if  in_ch ();
  pcs_out_if out_ch ();

  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  pci_config_scan_engine u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #2 clk_i = ~clk_i;

  int cycle_count = 0;
  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  // Predicted engine state and register
  logic [8:0]  m_bus_limit;
  phase_e      m_phase;
  logic [7:0]  m_bus;
  logic [4:0]  m_slot;
  logic [2:0]  m_fn;
  logic [2:0]  m_bar;
  logic [15:0] m_vendor;
  logic [15:0] m_device;

  res_t step_beats[$];     // beats caused by the latest input beat
  res_t scan_beats_q[$];   // beats still due on out_ch

  bit calm = 1'b0;         // no idling on either side while set
  int n_errors  = 0;
  int n_checked = 0;
  int n_beats   = 0;
  int n_starts  = 0;
  int n_found   = 0;
  int n_missing = 0;

  task automatic flag_mismatch(input string what);
    if (n_errors < 100) $display("[%0t] mismatch: %s", $realtime, what);
    n_errors++;
  endtask

  // Prediction ------------------------------------------------------------

  function automatic void emit(kind_e k, logic [31:0] addr, logic [2:0] bidx,
                               logic [31:0] val, logic fnd, logic lst);
    res_t r;
    r.kind            = k;
    r.config_address  = addr;
    r.bus_number      = m_bus;
    r.slot_number     = m_slot;
    r.function_number = m_fn;
    r.bar_index       = bidx;
    r.report_value    = val;
    r.found           = fnd;
    r.last            = lst;
    step_beats.push_back(r);
  endfunction

  function automatic void emit_read(logic [7:0] off);
    emit(KIND_REQ, {1'b1, 7'd0, m_bus, m_slot, m_fn, off & 8'hFC}, 3'd0, 32'd0, 1'b0, 1'b0);
  endfunction

  // Step to function 0 of the next slot, or finish when the buses run out
  function automatic void next_slot();
    int nb;
    m_fn   = 3'd0;
    m_slot = m_slot + 5'd1;
    if (m_slot == 5'd0 || int'(m_slot) >= SLOTS_PER_BUS_DEF) begin
      nb     = int'(m_bus) + 1;
      m_slot = 5'd0;
      if (nb >= int'(m_bus_limit) || nb >= 256) begin
        m_phase = PH_IDLE;
        emit(KIND_DONE, 32'd0, 3'd0, 32'd0, 1'b0, 1'b1);
        n_missing++;
        return;
      end
      m_bus = 8'(nb);
    end
    m_phase = PH_ID0;
    emit_read(OFF_ID);
  endfunction

  function automatic void begin_bars();
    m_phase = PH_BAR;
    m_bar   = 3'd0;
    emit_read(OFF_BAR0);
  endfunction

  function automatic void scan_step(in_t b);
    logic [31:0] rd;
    logic        hit;
    rd  = b.read_data;
    hit = (rd[15:0] == m_vendor) && (rd[31:16] == m_device);
    step_beats.delete();
    if (b.cmd == CMD_START) begin
      m_vendor = b.target_vendor;
      m_device = b.target_device;
      m_bus    = 8'd0;
      m_slot   = 5'd0;
      m_fn     = 3'd0;
      m_bar    = 3'd0;
      m_phase  = PH_ID0;
      emit_read(OFF_ID);
      n_starts++;
      return;
    end
    case (m_phase)
      PH_ID0: begin
        if (rd[15:0] == VENDOR_NONE) next_slot();
        else if (hit) begin_bars();
        else begin
          m_phase = PH_HDR;
          emit_read(OFF_HDR);
        end
      end
      PH_HDR: begin
        // Header type bit 7 marks a multi-function device
        if (rd[23]) begin
          m_fn    = 3'd1;
          m_phase = PH_IDF;
          emit_read(OFF_ID);
        end else begin
          next_slot();
        end
      end
      PH_IDF: begin
        if (rd[15:0] != VENDOR_NONE && hit) begin_bars();
        else if (m_fn == 3'd7) next_slot();
        else begin
          m_fn = m_fn + 3'd1;
          emit_read(OFF_ID);
        end
      end
      PH_BAR: begin
        emit(KIND_BAR, 32'd0, m_bar, rd, 1'b0, 1'b0);
        m_bar = m_bar + 3'd1;
        if (int'(m_bar) < BAR_COUNT_DEF) begin
          emit_read(OFF_BAR0 + {3'd0, m_bar, 2'b00});
        end else begin
          m_phase = PH_IRQ;
          emit_read(OFF_IRQ);
        end
      end
      PH_IRQ: begin
        emit(KIND_IRQ, 32'd0, 3'd0, {24'd0, rd[7:0]}, 1'b0, 1'b0);
        emit(KIND_DONE, 32'd0, 3'd0, 32'd0, 1'b1, 1'b1);
        m_phase = PH_IDLE;
        n_found++;
      end
      default: ;  // data while idle is dropped
    endcase
  endfunction

  // Stimulus helpers ------------------------------------------------------

  function automatic int short_or_long();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int pick_gap();
    if (calm || $urandom_range(0, 99) >= 35) return 0;
    return short_or_long();
  endfunction

  function automatic res_t build_beat(kind_e k, logic [31:0] addr, logic [7:0] bus,
                                      logic [4:0] slot, logic [2:0] fn);
    res_t r;
    r                 = '0;
    r.kind            = k;
    r.config_address  = addr;
    r.bus_number      = bus;
    r.slot_number     = slot;
    r.function_number = fn;
    return r;
  endfunction

  // Draw the next beat: mostly the answer a real config space would give
  function automatic in_t next_stimulus();
    in_t b;
    int  r;
    int  id_pick;
    b.cmd           = CMD_DATA;
    b.target_vendor = 16'($urandom);
    b.target_device = 16'($urandom);
    b.read_data     = $urandom;
    r               = $urandom_range(0, 99);
    if ((m_phase == PH_IDLE && r >= 12) || (m_phase != PH_IDLE && r < 3)) begin
      b.cmd   = CMD_START;
      id_pick = $urandom_range(0, 19);
      if (id_pick == 0) b.target_vendor = VENDOR_NONE;
      else if (id_pick == 1) begin
        b.target_vendor = 16'h0000;
        b.target_device = 16'h0000;
      end else if (id_pick == 2) b.target_device = 16'hFFFF;
      return b;
    end
    if (m_phase == PH_IDLE || r < 6) return b;
    r = $urandom_range(0, 99);
    case (m_phase)
      PH_ID0: begin
        if (r < 50) b.read_data[15:0] = VENDOR_NONE;
        else if (r < 56) b.read_data = {m_device, m_vendor};
        else if (b.read_data[15:0] == VENDOR_NONE) b.read_data[0] = 1'b0;
      end
      PH_HDR: b.read_data[23] = (r < 40);
      PH_IDF: begin
        if (r < 45) b.read_data[15:0] = VENDOR_NONE;
        else if (r < 53) b.read_data = {m_device, m_vendor};
      end
      default: begin
        if (r < 10) b.read_data = 32'h0000_0000;
        else if (r < 20) b.read_data = 32'hFFFF_FFFF;
      end
    endcase
    return b;
  endfunction

  // Present one beat and hold it until accepted
  task automatic send_beat(input in_t b, input int gap);
    @(negedge clk_i);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= b;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    n_beats++;
    scan_step(b);
  endtask

  task automatic end_burst();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
  endtask

  // Wait for every due beat, then let the engine settle
  task automatic wait_drained();
    int n;
    n = 0;
    while (scan_beats_q.size() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk_i);
      n++;
    end
    if (scan_beats_q.size() != 0) begin
      flag_mismatch($sformatf("%0d result beats never arrived", scan_beats_q.size()));
      scan_beats_q.delete();
    end
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic apb_access(input logic wr, input logic [APB_AW-1:0] a,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= a;
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Result checking -------------------------------------------------------

  always @(posedge clk_i) begin : check_results
    res_t got;
    res_t due;
    if (rst_ni === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got = out_ch.data;
      if (scan_beats_q.size() == 0) begin
        flag_mismatch($sformatf("result beat %h with nothing due", got));
      end else begin
        due = scan_beats_q.pop_front();
        n_checked++;
        if (got.kind !== due.kind)
          flag_mismatch($sformatf("kind %0d, want %0d", got.kind, due.kind));
        if (got.config_address !== due.config_address)
          flag_mismatch($sformatf("config_address %h, want %h",
                                  got.config_address, due.config_address));
        if (got.bus_number !== due.bus_number)
          flag_mismatch($sformatf("bus_number %0d, want %0d", got.bus_number, due.bus_number));
        if (got.slot_number !== due.slot_number)
          flag_mismatch($sformatf("slot_number %0d, want %0d",
                                  got.slot_number, due.slot_number));
        if (got.function_number !== due.function_number)
          flag_mismatch($sformatf("function_number %0d, want %0d",
                                  got.function_number, due.function_number));
        if (got.bar_index !== due.bar_index)
          flag_mismatch($sformatf("bar_index %0d, want %0d", got.bar_index, due.bar_index));
        if (got.report_value !== due.report_value)
          flag_mismatch($sformatf("report_value %h, want %h",
                                  got.report_value, due.report_value));
        if (got.found !== due.found)
          flag_mismatch($sformatf("found %b, want %b", got.found, due.found));
        if (got.last !== due.last)
          flag_mismatch($sformatf("last %b, want %b", got.last, due.last));
      end
    end
  end

  // Stall the result side at random
  initial begin : out_pacing
    int stall;
    stall        = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        stall--;
      end else begin
        out_ch.ready <= 1'b1;
        if (!calm && $urandom_range(0, 99) < 25) stall = short_or_long();
      end
    end
  end

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles", cycle_count);
    $display("testbench NOT OK");
    $finish;
  end

  // Main sequence ---------------------------------------------------------

  typedef struct {
    in_t  beat;
    int   n_typed;   // PREDICTED, or the number of typed beats (0 or 1)
    res_t typed;
  } dir_row_t;

  dir_row_t dir_rows[$];

  task automatic add_row(input cmd_e c, input logic [15:0] ven, input logic [15:0] dev,
                         input logic [31:0] rd, input int n_typed, input res_t typed);
    dir_row_t row;
    row.beat.cmd           = c;
    row.beat.target_vendor = ven;
    row.beat.target_device = dev;
    row.beat.read_data     = rd;
    row.n_typed            = n_typed;
    row.typed              = typed;
    dir_rows.push_back(row);
  endtask

  initial begin : stimulus
    logic [8:0]  lim_list [7];
    logic [31:0] rdata;
    res_t        none;
    in_t         b;
    int          counted;
    bit          dropped;

    none = '0;
    rst_ni      = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;

    m_bus_limit = BUS_LIMIT_RST;
    m_phase     = PH_IDLE;
    m_bus       = '0;
    m_slot      = '0;
    m_fn        = '0;
    m_bar       = '0;
    m_vendor    = '0;
    m_device    = '0;

    // Directed rows: idle data, empty slots, multi-function, restart, matches, all BARs
    add_row(CMD_DATA,  16'h0000, 16'h0000, 32'h1234_5678, 0, none);
    add_row(CMD_START, 16'hFFFF, 16'hFFFF, 32'h0000_0000, 1,
            build_beat(KIND_REQ, 32'h8000_0000, 8'd0, 5'd0, 3'd0));
    add_row(CMD_DATA,  16'h0000, 16'h0000, 32'hFFFF_FFFF, 1,
            build_beat(KIND_REQ, 32'h8000_0800, 8'd0, 5'd1, 3'd0));
    add_row(CMD_DATA,  16'h0000, 16'h0000, 32'h0000_0000, 1,
            build_beat(KIND_REQ, 32'h8000_080C, 8'd0, 5'd1, 3'd0));
    add_row(CMD_DATA,  16'h0000, 16'h0000, 32'h0080_0000, 1,
            build_beat(KIND_REQ, 32'h8000_0900, 8'd0, 5'd1, 3'd1));
    add_row(CMD_DATA,  16'h0000, 16'h0000, 32'h0000_FFFF, PREDICTED, none);
    add_row(CMD_DATA,  16'h0000, 16'h0000, 32'hFFFF_0000, PREDICTED, none);
    add_row(CMD_START, 16'h1234, 16'hABCD, 32'hFFFF_FFFF, 1,
            build_beat(KIND_REQ, 32'h8000_0000, 8'd0, 5'd0, 3'd0));
    add_row(CMD_DATA,  16'hFFFF, 16'hFFFF, 32'hABCD_1234, 1,
            build_beat(KIND_REQ, 32'h8000_0010, 8'd0, 5'd0, 3'd0));
    add_row(CMD_DATA,  16'h0000, 16'h0000, 32'h0000_0000, PREDICTED, none);
    add_row(CMD_DATA,  16'h0000, 16'h0000, 32'hFFFF_FFFF, PREDICTED, none);
    add_row(CMD_DATA,  16'h0000, 16'h0000, 32'h8000_0001, PREDICTED, none);
    add_row(CMD_DATA,  16'h0000, 16'h0000, 32'h7FFF_FFFE, PREDICTED, none);
    add_row(CMD_DATA,  16'h0000, 16'h0000, 32'hA5A5_5A5A, PREDICTED, none);
    add_row(CMD_DATA,  16'h0000, 16'h0000, 32'h0000_000C, PREDICTED, none);
    add_row(CMD_DATA,  16'h0000, 16'h0000, 32'hFFFF_FF3C, PREDICTED, none);
    add_row(CMD_DATA,  16'hFFFF, 16'hFFFF, 32'h0000_0000, 0, none);
    add_row(CMD_START, 16'h0000, 16'h0000, 32'h0000_0000, 1,
            build_beat(KIND_REQ, 32'h8000_0000, 8'd0, 5'd0, 3'd0));
    add_row(CMD_DATA,  16'h0000, 16'h0000, 32'h1234_0000, PREDICTED, none);
    add_row(CMD_DATA,  16'h0000, 16'h0000, 32'hFF7F_FFFF, PREDICTED, none);
    add_row(CMD_DATA,  16'h0000, 16'h0000, 32'h0000_0000, PREDICTED, none);
    add_row(CMD_START, 16'h5A5A, 16'hC3C3, 32'h0000_0000, PREDICTED, none);
    add_row(CMD_DATA,  16'h0000, 16'h0000, 32'h0000_0000, PREDICTED, none);
    add_row(CMD_DATA,  16'h0000, 16'h0000, 32'h0080_0000, PREDICTED, none);
    add_row(CMD_DATA,  16'h0000, 16'h0000, 32'hC3C3_5A5A, PREDICTED, none);

    // Hold reset, release on a falling edge
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset value of bus_limit reads back
    apb_access(1'b0, 3'd0, 32'd0, rdata);
    if (rdata !== {23'd0, m_bus_limit})
      flag_mismatch($sformatf("bus_limit reads %h after reset", rdata));

    foreach (dir_rows[i]) begin
      send_beat(dir_rows[i].beat, pick_gap());
      if (dir_rows[i].n_typed == PREDICTED) begin
        foreach (step_beats[j]) scan_beats_q.push_back(step_beats[j]);
      end else if (dir_rows[i].n_typed == 1) begin
        scan_beats_q.push_back(dir_rows[i].typed);
      end
    end
    end_burst();
    wait_drained();

    // Random scans over a range of bus_limit settings, extremes included
    lim_list = '{9'd1, 9'd0, 9'd256, 9'd511, 9'd2, 9'($urandom_range(3, 24)), BUS_LIMIT_RST};
    foreach (lim_list[s]) begin
      // Writes to an address with bit 2 set leave bus_limit alone
      if (s == 2) apb_access(1'b1, 3'd4, $urandom, rdata);
      apb_access(1'b1, 3'd0, ($urandom & ~32'h1FF) | {23'd0, lim_list[s]}, rdata);
      m_bus_limit = lim_list[s];
      apb_access(1'b0, 3'd0, 32'd0, rdata);
      if (rdata !== {23'd0, m_bus_limit})
        flag_mismatch($sformatf("bus_limit reads %h, want %h", rdata, m_bus_limit));

      calm    = (s % 3 == 1);
      counted = 0;
      while (counted < PER_SETTING) begin
        b       = next_stimulus();
        dropped = (b.cmd == CMD_DATA) && (m_phase == PH_IDLE);
        send_beat(b, pick_gap());
        foreach (step_beats[j]) scan_beats_q.push_back(step_beats[j]);
        if (!dropped) counted++;
      end
      end_burst();
      wait_drained();
    end
    calm = 1'b0;

    $display("covered %0d input beats (%0d starts) over %0d bus_limit settings",
             n_beats, n_starts, $size(lim_list) + 1);
    $display("checked %0d result beats; searches ended %0d found, %0d not found",
             n_checked, n_found, n_missing);
    if (n_errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
